// ----- rtl/core/date_check_and_format_top_assert.svh -----
// assertion helpers for the date checker and formatter
`ifndef DATE_CHECK_AND_FORMAT_TOP_ASSERT_SVH
`define DATE_CHECK_AND_FORMAT_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define DCF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define DCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/dcf_pkg.sv -----
package dcf_pkg;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_UNSUP   = 2'd2;

    // date format register codes
    localparam logic [2:0] FMT_COMPACT   = 3'd0;
    localparam logic [2:0] FMT_ISO       = 3'd1;
    localparam logic [2:0] FMT_LAST_SUPP = 3'd3;

    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_NINE   = 8'h39;
    localparam logic [7:0] ASCII_HYPHEN = 8'h2D;

    localparam int MAX_CHARS = 10;
    localparam int IDX_W     = $clog2(MAX_CHARS);

    localparam logic [IDX_W-1:0] LAST_IDX_SEP     = IDX_W'(MAX_CHARS - 1);
    localparam logic [IDX_W-1:0] LAST_IDX_COMPACT = IDX_W'(MAX_CHARS - 3);

    localparam logic [4:0] DAYS_LONG  = 5'd31;
    localparam logic [4:0] DAYS_SHORT = 5'd30;
    localparam logic [4:0] DAYS_FEB   = 5'd28;
    localparam logic [4:0] DAYS_LEAP  = 5'd29;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    // one double-dabble step: add-3 correction per digit, then shift in a bit
    function automatic logic [15:0] dd_step(logic [15:0] bcd, logic b);
        logic [15:0] adj;
        adj = bcd;
        for (int k = 0; k < 4; k++)
        begin
            if (adj[4*k +: 4] >= 4'd5)
            begin
                adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
            end
        end
        return {adj[14:0], b};
    endfunction

    function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
        logic [4:0] len;
        case (m)
            MONTH_FEB: len = leap ? DAYS_LEAP : DAYS_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
            default: len = DAYS_LONG;
        endcase
        return len;
    endfunction

    // dig holds eight bcd digits, year thousands in the top nibble, day ones at the bottom
    function automatic logic [7:0] date_char(logic [IDX_W-1:0] idx, logic sep,
                                             logic [31:0] dig);
        logic [2:0] k;
        logic       hyph;
        k    = 3'd0;
        hyph = 1'b0;
        if (sep)
        begin
            case (idx)
                4'd0, 4'd1, 4'd2, 4'd3: k = idx[2:0];
                4'd4, 4'd7:             hyph = 1'b1;
                4'd5, 4'd6:             k = 3'(idx - 4'd1);
                4'd8, 4'd9:             k = 3'(idx - 4'd2);
                default:                k = 3'd0;
            endcase
        end
        else
        begin
            k = idx[2:0];
        end
        if (hyph)
        begin
            return ASCII_HYPHEN;
        end
        return ASCII_ZERO + {4'd0, dig[(5'd28 - {k, 2'b00}) +: 4]};
    endfunction

endpackage

// ----- rtl/core/date_check_and_format_top.sv -----
// date checker and formatter
// input channel: in_valid / in_stall carry one timestamp per transfer (year, month,
//   day, hour, minute, second, fraction); the block raises in_stall when full
// config channel: cfg_valid / cfg_ready write date_format from cfg_data; cfg_ready
//   is always high; write only while the block is idle
// output channel: out_valid / out_stall carry one character per transfer, with last
//   on the final character of a timestamp and status (0 ok, 1 illegal, 2 format)
// a good date gives YYYY-MM-DD (10 transfers) or YYYYMMDD (8 transfers); a bad
//   date or an unsupported format gives one transfer with character zero
// path: the first character reaches the output through four pipeline stages
//   and then the output register
// serializer: drives one character per cycle while out_stall is low and holds
//   each timestamp for its 10, 8 or 1 characters; the stages before it
//   already take the next timestamps meanwhile
// reset: all stages empty, out_valid low, date_format back to iso (1)
// stall: out_stall holds the output register; the serializer and stages fill up
//   behind it and in_stall rises once stage one cannot move; nothing is lost
module date_check_and_format_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  year,
    input  logic        [15:0]  month,
    input  logic        [15:0]  day,
    input  logic        [15:0]  hour,
    input  logic        [15:0]  minute,
    input  logic        [15:0]  second,
    input  logic        [31:0]  fraction,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic        [2:0]   cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic        [7:0]   character,
    output logic                last,
    output logic        [1:0]   status
);

    `include "date_check_and_format_top_assert.svh"

    localparam int IW = dcf_pkg::IDX_W;

    // config register
    logic [2:0] date_format_reg;

    // stage 1: range checks done, narrowed fields
    logic        v1_reg;
    logic [13:0] y1_reg;
    logic [3:0]  m1_reg;
    logic [4:0]  d1_reg;
    logic        bad1_reg;

    // stage 2: upper seven year bits converted to bcd
    logic        v2_reg;
    logic [15:0] bcd2_reg;
    logic [6:0]  ylo2_reg;
    logic [3:0]  m2_reg;
    logic [4:0]  d2_reg;
    logic        bad2_reg;

    // stage 3: full year in bcd
    logic        v3_reg;
    logic [15:0] bcd3_reg;
    logic [1:0]  ylo3_reg;
    logic [3:0]  m3_reg;
    logic [4:0]  d3_reg;
    logic        bad3_reg;

    // stage 4: serializer, holds one timestamp while its characters go out
    logic          v4_reg;
    logic [31:0]   dig4_reg;
    logic [1:0]    st4_reg;
    logic          sep4_reg;
    logic [IW-1:0] idx4_reg;

    // output register
    logic       out_valid_reg;
    logic [7:0] character_reg;
    logic       last_reg;
    logic [1:0] status_reg;

    logic out_adv;
    logic s4_last;
    logic s4_free;
    logic s3_free;
    logic s2_free;
    logic s1_free;
    logic in_xfer;

    logic        bad1_next;
    logic [15:0] bcd2_next;
    logic [15:0] bcd3_next;
    logic        leap;
    logic        h100;
    logic [1:0]  cent_mod4;
    logic [4:0]  dlim;
    logic        bad4;
    logic [3:0]  mt;
    logic [3:0]  mo;
    logic [3:0]  dt;
    logic [3:0]  dn;
    logic [1:0]  st4_next;
    logic [7:0]  char_next;

    // ---------------- handshake and stage advance ----------------
    assign out_adv = !out_valid_reg || !out_stall;
    assign s4_last = (st4_reg != dcf_pkg::ST_OK) ||
                     (idx4_reg == (sep4_reg ? dcf_pkg::LAST_IDX_SEP
                                            : dcf_pkg::LAST_IDX_COMPACT));
    assign s4_free = !v4_reg || (out_adv && s4_last);
    assign s3_free = !v3_reg || s4_free;
    assign s2_free = !v2_reg || s3_free;
    assign s1_free = !v1_reg || s2_free;
    assign in_stall = !s1_free;
    assign in_xfer  = in_valid && s1_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_format_reg <= dcf_pkg::FMT_ISO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            date_format_reg <= cfg_data;
        end
    end

    // ---------------- stage 1: field range checks ----------------
    always_comb
    begin
        bad1_next = (hour != 16'd0) || (minute != 16'd0) || (second != 16'd0) ||
                    (fraction != 32'd0) ||
                    (year < 16'sd1) || (year > 16'sd9999) ||
                    (month < 16'd1) || (month > 16'd12) ||
                    (day < 16'd1) || (day > 16'd31);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            y1_reg   <= year[13:0];
            m1_reg   <= month[3:0];
            d1_reg   <= day[4:0];
            bad1_reg <= bad1_next;
        end
    end

    // ---------------- stage 2: year bits 13 to 7 into bcd ----------------
    always_comb
    begin
        bcd2_next = 16'd0;
        for (int i = 0; i < 7; i++)
        begin
            bcd2_next = dcf_pkg::dd_step(bcd2_next, y1_reg[13 - i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && v1_reg)
        begin
            bcd2_reg <= bcd2_next;
            ylo2_reg <= y1_reg[6:0];
            m2_reg   <= m1_reg;
            d2_reg   <= d1_reg;
            bad2_reg <= bad1_reg;
        end
    end

    // ---------------- stage 3: year bits 6 to 0 into bcd ----------------
    always_comb
    begin
        bcd3_next = bcd2_reg;
        for (int i = 0; i < 7; i++)
        begin
            bcd3_next = dcf_pkg::dd_step(bcd3_next, ylo2_reg[6 - i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (s3_free)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_free && v2_reg)
        begin
            bcd3_reg <= bcd3_next;
            ylo3_reg <= ylo2_reg[1:0];
            m3_reg   <= m2_reg;
            d3_reg   <= d2_reg;
            bad3_reg <= bad2_reg;
        end
    end

    // ---------------- stage 4: leap rule, day limit, format ----------------
    // divisible by 100: low two bcd digits zero; by 400 additionally needs
    // year/100 = 10*thousands + hundreds divisible by 4, i.e. 2*th + hu
    always_comb
    begin
        h100      = (bcd3_reg[7:0] == 8'd0);
        cent_mod4 = {bcd3_reg[12], 1'b0} + bcd3_reg[9:8];
        leap      = (ylo3_reg == 2'd0) && (!h100 || (cent_mod4 == 2'd0));
        dlim      = dcf_pkg::month_len(m3_reg, leap);
        bad4      = bad3_reg || (d3_reg > dlim);

        mt = (m3_reg >= 4'd10) ? 4'd1 : 4'd0;
        mo = (m3_reg >= 4'd10) ? (m3_reg - 4'd10) : m3_reg;

        if (d3_reg >= 5'd30)
        begin
            dt = 4'd3;
            dn = 4'(d3_reg - 5'd30);
        end
        else if (d3_reg >= 5'd20)
        begin
            dt = 4'd2;
            dn = 4'(d3_reg - 5'd20);
        end
        else if (d3_reg >= 5'd10)
        begin
            dt = 4'd1;
            dn = 4'(d3_reg - 5'd10);
        end
        else
        begin
            dt = 4'd0;
            dn = d3_reg[3:0];
        end

        if (bad4)
        begin
            st4_next = dcf_pkg::ST_ILLEGAL;
        end
        else if (date_format_reg > dcf_pkg::FMT_LAST_SUPP)
        begin
            st4_next = dcf_pkg::ST_UNSUP;
        end
        else
        begin
            st4_next = dcf_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg   <= 1'b0;
            idx4_reg <= '0;
        end
        else if (s4_free)
        begin
            v4_reg   <= v3_reg;
            idx4_reg <= '0;
        end
        else if (v4_reg && out_adv)
        begin
            idx4_reg <= idx4_reg + IW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_free && v3_reg)
        begin
            dig4_reg <= {bcd3_reg, mt, mo, dt, dn};
            st4_reg  <= st4_next;
            sep4_reg <= (date_format_reg != dcf_pkg::FMT_COMPACT);
        end
    end

    // ---------------- output register ----------------
    always_comb
    begin
        if (st4_reg != dcf_pkg::ST_OK)
        begin
            char_next = 8'd0;
        end
        else
        begin
            char_next = dcf_pkg::date_char(idx4_reg, sep4_reg, dig4_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && v4_reg)
        begin
            character_reg <= char_next;
            last_reg      <= s4_last;
            status_reg    <= st4_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;
    assign status    = status_reg;

    // ---------------- assertions ----------------
    `DCF_ASSERT_NOW(a_err_single, clk, rst_n,
        out_valid_reg && (status_reg != dcf_pkg::ST_OK),
        last_reg && (character_reg == 8'd0),
        "error result must be a single zero character")

    `DCF_ASSERT_NOW(a_ok_char, clk, rst_n,
        out_valid_reg && (status_reg == dcf_pkg::ST_OK),
        ((character_reg >= dcf_pkg::ASCII_ZERO) && (character_reg <= dcf_pkg::ASCII_NINE)) ||
        (character_reg == dcf_pkg::ASCII_HYPHEN),
        "good result must be a digit or hyphen")

    `DCF_ASSERT_NEXT(a_next_char, clk, rst_n,
        out_valid_reg && !out_stall && !last_reg,
        out_valid_reg,
        "character of an unfinished date missing in the next cycle")

    `DCF_ASSERT_NOW(a_idx_range, clk, rst_n,
        v4_reg,
        idx4_reg <= (sep4_reg ? dcf_pkg::LAST_IDX_SEP : dcf_pkg::LAST_IDX_COMPACT),
        "serializer index past the last character")

endmodule
